@@ hdl/quorum_cas_completion_tracker_assert.svh @@
`ifndef QUORUM_CAS_COMPLETION_TRACKER_ASSERT_SVH
`define QUORUM_CAS_COMPLETION_TRACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define QCCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define QCCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/qcct_pkg.sv @@
`timescale 1ns / 1ps

package qcct_pkg;

    localparam int SLOTS        = 64;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int MAX_REPLICAS = 16;
    localparam int REP_W        = $clog2(MAX_REPLICAS);
    localparam int CNT_W        = REP_W + 1;
    localparam int WIN_W        = 7;
    localparam int DONE_W       = 7;

    localparam logic [7:0] TAG_ACQ = 8'hE1;
    localparam logic [7:0] TAG_REP = 8'hE2;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_COMPL = 2'd1;
    localparam logic [1:0] KIND_ADV   = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLICAS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUORUM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY    = 3'd4;

    typedef enum logic [2:0] {
        ACT_IGNORED  = 3'd0,
        ACT_POST_ACQ = 3'd1,
        ACT_POST_REP = 3'd2,
        ACT_LOSER    = 3'd3,
        ACT_WINNER   = 3'd4,
        ACT_LOST     = 3'd5,
        ACT_BAD_SLOT = 3'd6,
        ACT_BAD_REP  = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ACQ  = 2'd1,
        PH_REP  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  start_slot;
        logic [63:0] work_id;
        logic [63:0] returned_value;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic [63:0] request_id;
        logic [63:0] compare_value;
        logic [63:0] swap_value;
        logic [3:0]  replica_index;
        logic [5:0]  slot_index;
        logic [31:0] log_round;
        logic        round_done;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [31:0]      gen;
        phase_t           phase;
        logic [CNT_W-1:0] responses;
        logic [CNT_W-1:0] successes;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [WIN_W-1:0] slot_window;
        logic [4:0]       replica_total;
        logic [4:0]       quorum_size;
        logic [15:0]      client_number;
        logic [63:0]      empty_marker;
    } cfg_t;

    typedef struct packed {
        action_t           action;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       gen;
        logic              wr_en;
        entry_t            wr_entry;
        logic              set_active;
        logic              clr_active;
        logic              count_inc;
        logic              advance;
        logic              fan;
    } dec_t;

    function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        r = w;
        if (w == '0)
        begin
            r = WIN_W'(1);
        end
        else if (w > WIN_W'(SLOTS))
        begin
            r = WIN_W'(SLOTS);
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] eff_replicas(input logic [4:0] c);
        logic [CNT_W-1:0] r;
        r = CNT_W'(c);
        if (c == '0)
        begin
            r = CNT_W'(1);
        end
        else if (c > 5'(MAX_REPLICAS))
        begin
            r = CNT_W'(MAX_REPLICAS);
        end
        return r;
    endfunction

endpackage

@@ hdl/qcct_ram.sv @@
`timescale 1ns / 1ps

module qcct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/qcct_decide.sv @@
`timescale 1ns / 1ps

module qcct_decide (
    input  qcct_pkg::item_t  item,
    input  qcct_pkg::entry_t entry_raw,
    input  logic             written,
    input  logic             active,
    input  qcct_pkg::cfg_t   cfg,
    input  logic [31:0]      round,
    output qcct_pkg::dec_t   dec
);

    logic [qcct_pkg::WIN_W-1:0] win;
    logic [qcct_pkg::CNT_W-1:0] nrep;
    qcct_pkg::entry_t           cur;
    logic [7:0]                 tag;
    logic [31:0]                gen;
    logic [15:0]                s16;
    logic [7:0]                 rep;
    logic [qcct_pkg::CNT_W-1:0] resp_new;
    logic [qcct_pkg::CNT_W-1:0] succ_new;
    logic [qcct_pkg::CNT_W-1:0] remaining;
    logic [qcct_pkg::CNT_W:0]   reach;

    assign win  = qcct_pkg::eff_window(cfg.slot_window);
    assign nrep = qcct_pkg::eff_replicas(cfg.replica_total);
    assign cur  = written ? entry_raw : '0;
    assign tag  = item.work_id[63:56];
    assign gen  = item.work_id[55:24];
    assign s16  = item.work_id[23:8];
    assign rep  = item.work_id[7:0];

    assign resp_new  = cur.responses + qcct_pkg::CNT_W'(1);
    assign succ_new  = cur.successes
                     + qcct_pkg::CNT_W'(item.returned_value == cfg.empty_marker);
    assign remaining = (resp_new >= nrep) ? '0 : nrep - resp_new;
    assign reach     = {1'b0, succ_new} + {1'b0, remaining};

    always_comb
    begin
        dec          = '0;
        dec.action   = qcct_pkg::ACT_IGNORED;
        dec.gen      = cur.gen;
        dec.wr_entry = cur;
        case (item.kind)
            qcct_pkg::KIND_START:
            begin
                dec.slot = item.start_slot;
                if ({1'b0, item.start_slot} >= win)
                begin
                    dec.action = qcct_pkg::ACT_BAD_SLOT;
                end
                else
                begin
                    dec.action             = qcct_pkg::ACT_POST_ACQ;
                    dec.wr_en              = 1'b1;
                    dec.set_active         = 1'b1;
                    dec.wr_entry.gen       = cur.gen + 32'd1;
                    dec.wr_entry.phase     = qcct_pkg::PH_ACQ;
                    dec.wr_entry.responses = '0;
                    dec.wr_entry.successes = '0;
                    dec.gen                = cur.gen + 32'd1;
                end
            end
            qcct_pkg::KIND_ADV:
            begin
                dec.advance = 1'b1;
            end
            qcct_pkg::KIND_COMPL:
            begin
                if (tag == qcct_pkg::TAG_ACQ || tag == qcct_pkg::TAG_REP)
                begin
                    dec.slot = s16[qcct_pkg::SLOT_W-1:0];
                    if (s16 >= {9'b0, win})
                    begin
                        dec.action = qcct_pkg::ACT_BAD_SLOT;
                    end
                    else if (!active || cur.gen != gen)
                    begin
                        dec.action = qcct_pkg::ACT_IGNORED;
                    end
                    else if (tag == qcct_pkg::TAG_ACQ)
                    begin
                        if (cur.phase != qcct_pkg::PH_ACQ)
                        begin
                            dec.action = qcct_pkg::ACT_IGNORED;
                        end
                        else if (item.returned_value != {32'b0, round})
                        begin
                            dec.action     = qcct_pkg::ACT_LOSER;
                            dec.clr_active = 1'b1;
                            dec.count_inc  = 1'b1;
                        end
                        else
                        begin
                            dec.action             = qcct_pkg::ACT_POST_REP;
                            dec.fan                = 1'b1;
                            dec.wr_en              = 1'b1;
                            dec.wr_entry.phase     = qcct_pkg::PH_REP;
                            dec.wr_entry.responses = '0;
                            dec.wr_entry.successes = '0;
                        end
                    end
                    else
                    begin
                        if (cur.phase != qcct_pkg::PH_REP)
                        begin
                            dec.action = qcct_pkg::ACT_IGNORED;
                        end
                        else if (rep >= 8'(nrep))
                        begin
                            dec.action = qcct_pkg::ACT_BAD_REP;
                        end
                        else if (succ_new >= qcct_pkg::CNT_W'(cfg.quorum_size))
                        begin
                            dec.action     = qcct_pkg::ACT_WINNER;
                            dec.clr_active = 1'b1;
                            dec.count_inc  = 1'b1;
                        end
                        else if (reach < (qcct_pkg::CNT_W + 1)'(cfg.quorum_size))
                        begin
                            dec.action     = qcct_pkg::ACT_LOST;
                            dec.clr_active = 1'b1;
                        end
                        else
                        begin
                            dec.action             = qcct_pkg::ACT_IGNORED;
                            dec.wr_en              = 1'b1;
                            dec.wr_entry.responses = resp_new;
                            dec.wr_entry.successes = succ_new;
                        end
                    end
                end
            end
            default:
            begin
                dec.action = qcct_pkg::ACT_IGNORED;
            end
        endcase
    end

endmodule

@@ hdl/quorum_cas_completion_tracker.sv @@
`timescale 1ns / 1ps

// Slot tracker for a quorum test-and-set over remote compare-and-swap. An item is taken when
// start is high and busy is low; the slot entry is read from the slot table memory in that
// cycle, and in the next cycle (busy high) it is decided, written back and the first result is
// registered; results show on the result port with result_valid, one beat per cycle. The
// receiver cannot stall: every beat must be taken in the cycle it is shown. Most items give one
// beat; a won acquire gives one replicate beat per effective replica on consecutive cycles. Busy
// stays high until the last beat is registered, so no new item is taken before then. The slot
// table has a registered read, and fan-out uses the single result port. Per-slot active and
// written bits sit in flip-flops, so reset and a round advance take effect at once, with no
// clearing pass.

module quorum_cas_completion_tracker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  qcct_pkg::item_t                     item,
    output logic                                result_valid,
    output qcct_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [qcct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [63:0]                         cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_FAN  = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    qcct_pkg::item_t               item_reg;
    qcct_pkg::cfg_t                cfg_reg;
    logic [31:0]                   round_reg, round_next;
    logic [qcct_pkg::DONE_W-1:0]   count_reg, count_next;
    logic [qcct_pkg::SLOTS-1:0]    active_reg, active_next;
    logic [qcct_pkg::SLOTS-1:0]    written_reg, written_next;
    logic [qcct_pkg::REP_W-1:0]    fan_idx_reg, fan_idx_next;
    logic [qcct_pkg::SLOT_W-1:0]   fan_slot_reg, fan_slot_next;
    logic [31:0]                   fan_gen_reg, fan_gen_next;
    qcct_pkg::result_t             result_reg, result_next;
    logic                          result_valid_reg, result_valid_next;

    logic                          accept;
    logic [qcct_pkg::SLOT_W-1:0]   rd_addr;
    logic [qcct_pkg::SLOT_W-1:0]   cur_addr;
    logic [qcct_pkg::ENTRY_W-1:0]  rd_data;
    logic                          wr_en;
    qcct_pkg::dec_t                dec;
    logic [qcct_pkg::WIN_W-1:0]    win;
    logic [qcct_pkg::CNT_W-1:0]    nrep;
    logic [qcct_pkg::CNT_W-1:0]    last_rep;

    function automatic qcct_pkg::result_t rep_beat(
        input logic [qcct_pkg::REP_W-1:0]  idx,
        input logic [qcct_pkg::SLOT_W-1:0] slot,
        input logic [31:0]                 gen,
        input qcct_pkg::cfg_t              cfg,
        input logic [qcct_pkg::CNT_W-1:0]  last_idx
    );
        qcct_pkg::result_t r;
        r               = '0;
        r.action        = qcct_pkg::ACT_POST_REP;
        r.request_id    = {qcct_pkg::TAG_REP, gen, (16 - qcct_pkg::SLOT_W)'(0), slot,
                           (8 - qcct_pkg::REP_W)'(0), idx};
        r.compare_value = cfg.empty_marker;
        r.swap_value    = {48'b0, cfg.client_number};
        r.replica_index = idx;
        r.slot_index    = slot;
        r.last          = ({1'b0, idx} == last_idx);
        return r;
    endfunction

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign rd_addr  = (item.kind == qcct_pkg::KIND_START) ? item.start_slot
                                                         : item.work_id[13:8];
    assign cur_addr = (item_reg.kind == qcct_pkg::KIND_START) ? item_reg.start_slot
                                                             : item_reg.work_id[13:8];
    assign wr_en    = (state_reg == ST_EXEC) && dec.wr_en;

    assign win      = qcct_pkg::eff_window(cfg_reg.slot_window);
    assign nrep     = qcct_pkg::eff_replicas(cfg_reg.replica_total);
    assign last_rep = nrep - qcct_pkg::CNT_W'(1);

    qcct_ram #(
        .WIDTH (qcct_pkg::ENTRY_W),
        .DEPTH (qcct_pkg::SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cur_addr),
        .wr_data (dec.wr_entry),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    qcct_decide u_decide (
        .item      (item_reg),
        .entry_raw (qcct_pkg::entry_t'(rd_data)),
        .written   (written_reg[cur_addr]),
        .active    (active_reg[cur_addr]),
        .cfg       (cfg_reg),
        .round     (round_reg),
        .dec       (dec)
    );

    always_comb
    begin
        state_next        = state_reg;
        round_next        = round_reg;
        count_next        = count_reg;
        active_next       = active_reg;
        written_next      = written_reg;
        fan_idx_next      = fan_idx_reg;
        fan_slot_next     = fan_slot_reg;
        fan_gen_next      = fan_gen_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (dec.advance)
                begin
                    round_next  = round_reg + 32'd1;
                    count_next  = '0;
                    active_next = '0;
                end
                if (dec.count_inc && count_reg != '1)
                begin
                    count_next = count_reg + qcct_pkg::DONE_W'(1);
                end
                if (dec.set_active)
                begin
                    active_next[cur_addr]  = 1'b1;
                    written_next[cur_addr] = 1'b1;
                end
                if (dec.clr_active)
                begin
                    active_next[cur_addr] = 1'b0;
                end
                result_valid_next = 1'b1;
                if (dec.fan)
                begin
                    result_next   = rep_beat('0, dec.slot, dec.gen, cfg_reg, last_rep);
                    fan_slot_next = dec.slot;
                    fan_gen_next  = dec.gen;
                    fan_idx_next  = qcct_pkg::REP_W'(1);
                    state_next    = (last_rep == '0) ? ST_IDLE : ST_FAN;
                end
                else
                begin
                    result_next            = '0;
                    result_next.action     = dec.action;
                    result_next.slot_index = dec.slot;
                    result_next.last       = 1'b1;
                    if (dec.action == qcct_pkg::ACT_POST_ACQ)
                    begin
                        result_next.request_id    = {qcct_pkg::TAG_ACQ, dec.gen,
                                                     (16 - qcct_pkg::SLOT_W)'(0), dec.slot,
                                                     8'b0};
                        result_next.compare_value = {32'b0, round_reg};
                        result_next.swap_value    = 64'(round_reg) + 64'd1;
                    end
                    state_next = ST_IDLE;
                end
                result_next.log_round  = round_next;
                result_next.round_done = (count_next >= win);
            end
            ST_FAN:
            begin
                result_valid_next      = 1'b1;
                result_next            = rep_beat(fan_idx_reg, fan_slot_reg, fan_gen_reg,
                                                  cfg_reg, last_rep);
                result_next.log_round  = round_reg;
                result_next.round_done = (count_reg >= win);
                fan_idx_next           = fan_idx_reg + qcct_pkg::REP_W'(1);
                if ({1'b0, fan_idx_reg} == last_rep)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                 <= ST_IDLE;
            round_reg                 <= '0;
            count_reg                 <= '0;
            active_reg                <= '0;
            written_reg               <= '0;
            result_valid_reg          <= 1'b0;
            cfg_reg.slot_window       <= qcct_pkg::WIN_W'(1);
            cfg_reg.replica_total     <= 5'd3;
            cfg_reg.quorum_size       <= 5'd2;
            cfg_reg.client_number     <= '0;
            cfg_reg.empty_marker      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            round_reg        <= round_next;
            count_reg        <= count_next;
            active_reg       <= active_next;
            written_reg      <= written_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    qcct_pkg::CFG_WINDOW:   cfg_reg.slot_window   <= cfg_data[qcct_pkg::WIN_W-1:0];
                    qcct_pkg::CFG_REPLICAS: cfg_reg.replica_total <= cfg_data[4:0];
                    qcct_pkg::CFG_QUORUM:   cfg_reg.quorum_size   <= cfg_data[4:0];
                    qcct_pkg::CFG_CLIENT:   cfg_reg.client_number <= cfg_data[15:0];
                    qcct_pkg::CFG_EMPTY:    cfg_reg.empty_marker  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        fan_idx_reg  <= fan_idx_next;
        fan_slot_reg <= fan_slot_next;
        fan_gen_reg  <= fan_gen_next;
        result_reg   <= result_next;
    end

endmodule

@@ hdl/qcct_checker.sv @@
`timescale 1ns / 1ps

`include "quorum_cas_completion_tracker_assert.svh"

module qcct_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input qcct_pkg::result_t result
);

    `QCCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `QCCT_ASSERT_NOW(a_beat_from_busy, result_valid, $past(busy), "beat without a busy cycle")
    `QCCT_ASSERT_NEXT(a_fan_continues, result_valid && !result.last, result_valid, "fan-out broke")
    `QCCT_ASSERT_NOW(a_single_last, result_valid && result.action != qcct_pkg::ACT_POST_REP, result.last, "single beat not marked last")

endmodule

bind quorum_cas_completion_tracker qcct_checker u_qcct_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import qcct_pkg::*;

    localparam int         RUN_LIMIT    = 400000;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    item_t                item         = '0;
    logic                 result_valid;
    result_t              result;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [63:0]          cfg_data     = '0;

    // register copies for the tracker model
    logic [6:0]  window_reg   = 7'd1;
    logic [4:0]  replicas_reg = 5'd3;
    logic [4:0]  quorum_reg   = 5'd2;
    logic [15:0] client_reg   = '0;
    logic [63:0] empty_reg    = '0;

    // tracker model state
    logic        slot_live  [SLOTS];
    logic [31:0] slot_gen   [SLOTS];
    phase_t      slot_phase [SLOTS];
    int unsigned slot_resp  [SLOTS];
    int unsigned slot_succ  [SLOTS];
    logic [31:0] round_now  = '0;
    logic [6:0]  done_count = '0;
    result_t     owed_actions [$];

    // stimulus-side view of generations and round
    logic [31:0] stim_gen [SLOTS];
    logic [31:0] stim_round = '0;
    item_t       pending_items [$];

    int max_gap        = 16;
    int gap_left       = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    quorum_cas_completion_tracker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned window_eff();
        if (window_reg == '0)
            return 1;
        if (window_reg > SLOTS)
            return SLOTS;
        return window_reg;
    endfunction

    function automatic int unsigned replicas_eff();
        if (replicas_reg == '0)
            return 1;
        if (replicas_reg > MAX_REPLICAS)
            return MAX_REPLICAS;
        return replicas_reg;
    endfunction

    function automatic void owe(input action_t act, input logic [63:0] rid, cmp, swp,
                                input logic [3:0] rep, input logic [5:0] slot,
                                input logic last);
        result_t r;
        r.action        = act;
        r.request_id    = rid;
        r.compare_value = cmp;
        r.swap_value    = swp;
        r.replica_index = rep;
        r.slot_index    = slot;
        r.log_round     = round_now;
        r.round_done    = (done_count >= window_eff());
        r.last          = last;
        owed_actions.push_back(r);
    endfunction

    function automatic void close_slot(input logic [5:0] s, input logic counted);
        slot_live[s]  = 1'b0;
        slot_phase[s] = PH_IDLE;
        if (counted && done_count != 7'd127)
            done_count = done_count + 7'd1;
    endfunction

    function automatic void step_tracker(input item_t it);
        logic [7:0]  tag;
        logic [31:0] gen;
        logic [15:0] sl;
        logic [7:0]  rep;
        logic [5:0]  s;
        int unsigned nrep;
        int unsigned left;
        tag  = it.work_id[63:56];
        gen  = it.work_id[55:24];
        sl   = it.work_id[23:8];
        rep  = it.work_id[7:0];
        s    = sl[5:0];
        nrep = replicas_eff();
        if (it.kind == KIND_START)
        begin
            s = it.start_slot;
            if (s >= window_eff())
                owe(ACT_BAD_SLOT, '0, '0, '0, '0, s, 1'b1);
            else
            begin
                slot_live[s]  = 1'b1;
                slot_gen[s]   = slot_gen[s] + 32'd1;
                slot_phase[s] = PH_ACQ;
                slot_resp[s]  = 0;
                slot_succ[s]  = 0;
                owe(ACT_POST_ACQ, {TAG_ACQ, slot_gen[s], 10'd0, s, 8'd0}, {32'd0, round_now},
                    {32'd0, round_now} + 64'd1, '0, s, 1'b1);
            end
        end
        else if (it.kind == KIND_ADV)
        begin
            round_now  = round_now + 32'd1;
            done_count = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_live[i]  = 1'b0;
                slot_phase[i] = PH_IDLE;
            end
            owe(ACT_IGNORED, '0, '0, '0, '0, '0, 1'b1);
        end
        else if (it.kind == KIND_COMPL)
        begin
            if (tag != TAG_ACQ && tag != TAG_REP)
                owe(ACT_IGNORED, '0, '0, '0, '0, '0, 1'b1);
            else if (sl >= window_eff())
                owe(ACT_BAD_SLOT, '0, '0, '0, '0, s, 1'b1);
            else if (!slot_live[s] || slot_gen[s] != gen)
                owe(ACT_IGNORED, '0, '0, '0, '0, s, 1'b1);
            else if (tag == TAG_ACQ)
            begin
                if (slot_phase[s] != PH_ACQ)
                    owe(ACT_IGNORED, '0, '0, '0, '0, s, 1'b1);
                else if (it.returned_value != {32'd0, round_now})
                begin
                    close_slot(s, 1'b1);
                    owe(ACT_LOSER, '0, '0, '0, '0, s, 1'b1);
                end
                else
                begin
                    slot_phase[s] = PH_REP;
                    slot_resp[s]  = 0;
                    slot_succ[s]  = 0;
                    for (int i = 0; i < nrep; i++)
                        owe(ACT_POST_REP, {TAG_REP, gen, 10'd0, s, 4'd0, 4'(i)}, empty_reg,
                            {48'd0, client_reg}, 4'(i), s, i == nrep - 1);
                end
            end
            else if (slot_phase[s] != PH_REP)
                owe(ACT_IGNORED, '0, '0, '0, '0, s, 1'b1);
            else if (rep >= nrep)
                owe(ACT_BAD_REP, '0, '0, '0, '0, s, 1'b1);
            else
            begin
                slot_resp[s] = slot_resp[s] + 1;
                if (it.returned_value == empty_reg)
                    slot_succ[s] = slot_succ[s] + 1;
                left = (slot_resp[s] >= nrep) ? 0 : nrep - slot_resp[s];
                if (slot_succ[s] >= quorum_reg)
                begin
                    close_slot(s, 1'b1);
                    owe(ACT_WINNER, '0, '0, '0, '0, s, 1'b1);
                end
                else if (slot_succ[s] + left < quorum_reg)
                begin
                    close_slot(s, 1'b0);
                    owe(ACT_LOST, '0, '0, '0, '0, s, 1'b1);
                end
                else
                    owe(ACT_IGNORED, '0, '0, '0, '0, s, 1'b1);
            end
        end
        else
            owe(ACT_IGNORED, '0, '0, '0, '0, '0, 1'b1);
    endfunction

    function automatic item_t start_beat(input logic [5:0] s);
        item_t it;
        it.kind           = KIND_START;
        it.start_slot     = s;
        it.work_id        = {$urandom, $urandom};
        it.returned_value = {$urandom, $urandom};
        if (s < window_eff())
            stim_gen[s] = stim_gen[s] + 32'd1;
        return it;
    endfunction

    function automatic item_t done_beat(input logic [7:0] tag, input logic [31:0] gen,
                                        input logic [15:0] sl, input logic [7:0] rep,
                                        input logic [63:0] ret);
        item_t it;
        it.kind           = KIND_COMPL;
        it.start_slot     = 6'($urandom);
        it.work_id        = {tag, gen, sl, rep};
        it.returned_value = ret;
        return it;
    endfunction

    function automatic item_t advance_beat();
        item_t it;
        it.kind           = KIND_ADV;
        it.start_slot     = 6'($urandom);
        it.work_id        = {$urandom, $urandom};
        it.returned_value = {$urandom, $urandom};
        stim_round        = stim_round + 32'd1;
        return it;
    endfunction

    function automatic item_t noise_beat();
        item_t       it;
        logic [5:0]  s;
        logic [7:0]  tag;
        logic [63:0] ret;
        s   = 6'($urandom);
        tag = ($urandom_range(0, 1) == 0) ? TAG_ACQ : TAG_REP;
        ret = ($urandom_range(0, 1) == 0) ? empty_reg : {32'd0, stim_round};
        it.kind           = KIND_COMPL;
        it.start_slot     = s;
        it.work_id        = {$urandom, $urandom};
        it.returned_value = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: it = start_beat(s);
            1: it.kind = KIND_UNKNOWN;
            2: it.kind = KIND_COMPL;
            3: it = done_beat(tag, stim_gen[s] - 32'd1, 16'(s), 8'($urandom), ret);
            default: it = done_beat(tag, stim_gen[s], 16'(s), 8'($urandom_range(0, 17)), ret);
        endcase
        return it;
    endfunction

    // one slot: arm, acquire, then, if the acquire wins, replicate responses in random order
    task automatic build_txn(input logic [5:0] s, ref item_t q[$]);
        int unsigned order [$];
        int unsigned nrep;
        int unsigned j;
        int unsigned tmp;
        logic [31:0] g;
        logic [63:0] ret;
        nrep = replicas_eff();
        q.push_back(start_beat(s));
        g = stim_gen[s];
        if ($urandom_range(0, 3) == 0)
            q.push_back(done_beat(TAG_ACQ, g, 16'(s), 8'($urandom), {$urandom, $urandom}));
        else
        begin
            q.push_back(done_beat(TAG_ACQ, g, 16'(s), 8'($urandom), {32'd0, stim_round}));
            for (int i = 0; i < nrep; i++)
                order.push_back(i);
            for (int i = nrep - 1; i > 0; i--)
            begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            if ($urandom_range(0, 7) == 0)
                q.push_back(done_beat(TAG_ACQ, g, 16'(s), 8'd0, {32'd0, stim_round}));
            foreach (order[k])
            begin
                if ($urandom_range(0, 9) == 0)
                    q.push_back(done_beat(TAG_REP, g, 16'(s), 8'($urandom_range(nrep, 255)),
                                          empty_reg));
                ret = ($urandom_range(0, 9) < 7) ? empty_reg : {$urandom, $urandom};
                q.push_back(done_beat(TAG_REP, g, 16'(s), 8'(order[k]), ret));
            end
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || start || owed_actions.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WINDOW:   window_reg   = val[6:0];
            CFG_REPLICAS: replicas_reg = val[4:0];
            CFG_QUORUM:   quorum_reg   = val[4:0];
            CFG_CLIENT:   client_reg   = val[15:0];
            CFG_EMPTY:    empty_reg    = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [6:0] w, input logic [4:0] r, qs,
                             input logic [15:0] c, input logic [63:0] e);
        write_reg(CFG_WINDOW, {$urandom, 25'($urandom), w});
        write_reg(CFG_REPLICAS, {$urandom, 27'($urandom), r});
        write_reg(CFG_QUORUM, {$urandom, 27'($urandom), qs});
        write_reg(CFG_CLIENT, {$urandom, 16'($urandom), c});
        write_reg(CFG_EMPTY, e);
    endtask

    task automatic run_traffic(input int pairs, input int gap);
        item_t       qa [$];
        item_t       qb [$];
        logic [5:0]  sa;
        logic [5:0]  sb;
        int unsigned win;
        @(negedge clk);
        max_gap = gap;
        win     = window_eff();
        for (int p = 0; p < pairs; p++)
        begin
            sa = 6'($urandom_range(0, win - 1));
            sb = 6'($urandom_range(0, win - 1));
            if (sb == sa && win > 1)
                sb = 6'((sa + 1) % win);
            build_txn(sa, qa);
            build_txn(sb, qb);
            while (qa.size() + qb.size() != 0)
            begin
                if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 0))
                    pending_items.push_back(qa.pop_front());
                else
                    pending_items.push_back(qb.pop_front());
                if ($urandom_range(0, 11) == 0)
                    pending_items.push_back(noise_beat());
            end
            if ($urandom_range(0, 3) == 0)
                pending_items.push_back(advance_beat());
        end
        drain();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : feed_items
        int wait_n;
        if (!rst_n)
        begin
            start    <= 1'b0;
            item     <= '0;
            gap_left <= 0;
        end
        else
        begin
            wait_n = gap_left;
            if (start && !busy)
            begin
                step_tracker(item);
                wait_n = $urandom_range(0, max_gap);
            end
            if (!(start && busy))
            begin
                if (wait_n > 0)
                begin
                    start    <= 1'b0;
                    gap_left <= wait_n - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    item  <= pending_items.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want, got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid)
        begin
            if (owed_actions.size() == 0)
            begin
                $display("%0t: beat expected none got %h", $time, result);
                mismatch_count++;
            end
            else
            begin
                want = owed_actions.pop_front();
                check_field("action", 64'(want.action), 64'(result.action));
                check_field("request_id", want.request_id, result.request_id);
                check_field("compare_value", want.compare_value, result.compare_value);
                check_field("swap_value", want.swap_value, result.swap_value);
                check_field("replica_index", 64'(want.replica_index), 64'(result.replica_index));
                check_field("slot_index", 64'(want.slot_index), 64'(result.slot_index));
                check_field("log_round", 64'(want.log_round), 64'(result.log_round));
                check_field("round_done", 64'(want.round_done), 64'(result.round_done));
                check_field("last", 64'(want.last), 64'(result.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_live[i]  = 1'b0;
            slot_gen[i]   = '0;
            slot_phase[i] = PH_IDLE;
            slot_resp[i]  = 0;
            slot_succ[i]  = 0;
            stim_gen[i]   = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: window 1, three replicas, quorum two
        pending_items.push_back(start_beat(6'd0));
        pending_items.push_back(start_beat(6'd5));
        pending_items.push_back(done_beat(TAG_ACQ, stim_gen[0], 16'd0, 8'd0, 64'd1));
        pending_items.push_back(advance_beat());
        pending_items.push_back('{kind: KIND_UNKNOWN, start_slot: 6'h3F, work_id: '1,
                                  returned_value: '1});
        pending_items.push_back(done_beat(8'hFF, '1, '1, 8'hFF, '1));
        pending_items.push_back(start_beat(6'd0));
        pending_items.push_back(done_beat(TAG_ACQ, stim_gen[0], 16'd0, 8'd0, 64'd1));
        pending_items.push_back(done_beat(TAG_ACQ, stim_gen[0], 16'd0, 8'd0, 64'd1));
        pending_items.push_back(done_beat(TAG_REP, stim_gen[0], 16'd0, 8'd5, 64'd0));
        pending_items.push_back(done_beat(TAG_REP, stim_gen[0], 16'd300, 8'd0, 64'd0));
        pending_items.push_back(done_beat(TAG_REP, stim_gen[0] - 32'd1, 16'd0, 8'd0, 64'd0));
        pending_items.push_back(done_beat(TAG_REP, stim_gen[0], 16'd0, 8'd0, 64'd0));
        pending_items.push_back(done_beat(TAG_REP, stim_gen[0], 16'd0, 8'd1, 64'd0));
        pending_items.push_back(start_beat(6'd0));
        pending_items.push_back(done_beat(TAG_ACQ, stim_gen[0], 16'd0, 8'd0, 64'd1));
        pending_items.push_back(done_beat(TAG_REP, stim_gen[0], 16'd0, 8'd2, 64'd5));
        pending_items.push_back(done_beat(TAG_REP, stim_gen[0], 16'd0, 8'd0, 64'd7));
        pending_items.push_back(start_beat(6'd0));
        pending_items.push_back(start_beat(6'd0));
        pending_items.push_back(done_beat(TAG_ACQ, stim_gen[0] - 32'd1, 16'd0, 8'd0, 64'd1));
        pending_items.push_back(done_beat(TAG_ACQ, stim_gen[0], 16'd0, 8'd0, 64'd0));
        pending_items.push_back(advance_beat());
        pending_items.push_back('{kind: KIND_UNKNOWN, start_slot: '0, work_id: '0,
                                  returned_value: '0});
        drain();

        configure(7'd127, 5'd31, 5'd9, 16'hFFFF, '1);
        run_traffic(1, 0);
        configure(7'd0, 5'd0, 5'd0, 16'($urandom), {$urandom, $urandom});
        run_traffic(1, 16);
        configure(7'd8, 5'd5, 5'd3, 16'($urandom), {$urandom, $urandom});
        run_traffic(2, 4);
        configure(7'd3, 5'd2, 5'd1, 16'($urandom), {$urandom, $urandom});
        run_traffic(1, 16);

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ quorum_cas_completion_tracker.f @@
+incdir+hdl
hdl/qcct_pkg.sv
hdl/qcct_ram.sv
hdl/qcct_decide.sv
hdl/quorum_cas_completion_tracker.sv
hdl/qcct_checker.sv
tb/sv/tb.sv
